// File: rtl/fd_attribute_closure_assert.svh
// assertion macros used by the checker of this block
`ifndef FD_ATTRIBUTE_CLOSURE_ASSERT_SVH
`define FD_ATTRIBUTE_CLOSURE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define FDAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fdac assertion failed");

// consequent holds in the cycle after the antecedent
`define FDAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fdac assertion failed");

`endif

// File: rtl/fdac_pkg.sv
`default_nettype none

package fdac_pkg;

	localparam int NUM_ATTRS = 32;
	localparam int NUM_DEPS  = 64;

	localparam int SET_W   = 32;
	localparam int INDEX_W = 6;
	localparam int ADDR_W  = (NUM_DEPS > 1) ? $clog2(NUM_DEPS) : 1;

	// attribute positions at NUM_ATTRS and above are dropped
	localparam logic [SET_W-1:0] ATTR_MASK = (NUM_ATTRS >= SET_W) ? {SET_W{1'b1}} :
		SET_W'((65'd1 << NUM_ATTRS) - 65'd1);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_DEPS - 1);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic              wr_entry;
		logic              load_query;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              apply;
		logic              clear_changed;
		logic              load_result;
	} cmd_t;

	typedef struct packed {
		logic changed;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/fdac_in_if.sv
`default_nettype none

interface fdac_in_if import fdac_pkg::*;;
	logic               valid;
	logic               ready;
	logic               action;
	logic [INDEX_W-1:0] entry_index;
	logic               entry_valid;
	logic [SET_W-1:0]   left_attrs;
	logic [SET_W-1:0]   right_attrs;
	logic [SET_W-1:0]   start_set;
	logic [SET_W-1:0]   target_set;

	modport source (
		output valid, action, entry_index, entry_valid, left_attrs, right_attrs,
		       start_set, target_set,
		input  ready
	);

	modport sink (
		input  valid, action, entry_index, entry_valid, left_attrs, right_attrs,
		       start_set, target_set,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/fdac_out_if.sv
`default_nettype none

interface fdac_out_if import fdac_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SET_W-1:0] closure_set;
	logic             is_implied;

	modport source (
		output valid, closure_set, is_implied,
		input  ready
	);

	modport sink (
		input  valid, closure_set, is_implied,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/fdac_ctrl.sv
`default_nettype none

module fdac_ctrl import fdac_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_action,
	output logic         in_ready,
	input  wire logic    out_ready,
	output logic         out_valid,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_TAIL  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [ADDR_W-1:0] idx_q;
	logic              apply_s1;
	logic              out_valid_q;
	logic              in_beat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d           = state_q;
		cmd.wr_entry      = in_beat && (in_action == ACT_WRITE);
		cmd.load_query    = in_beat && (in_action == ACT_QUERY);
		cmd.rd_en         = 1'b0;
		cmd.rd_addr       = idx_q;
		cmd.apply         = apply_s1;
		cmd.clear_changed = 1'b0;
		cmd.load_result   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat && (in_action == ACT_QUERY)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (idx_q == LAST_ADDR) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// another pass while the last one grew the set
				if (status.changed) begin
					cmd.clear_changed = 1'b1;
					state_d           = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			apply_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			apply_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				idx_q <= (idx_q == LAST_ADDR) ? '0 : idx_q + 1'b1;
			end else if (state_q != ST_TAIL) begin
				idx_q <= '0;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/fdac_dpath.sv
`default_nettype none

module fdac_dpath import fdac_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic [INDEX_W-1:0] entry_index,
	input  wire logic               entry_valid,
	input  wire logic [SET_W-1:0]   left_attrs,
	input  wire logic [SET_W-1:0]   right_attrs,
	input  wire logic [SET_W-1:0]   start_set,
	input  wire logic [SET_W-1:0]   target_set,
	output logic      [SET_W-1:0]   closure_set,
	output logic                    is_implied
);

	logic [SET_W-1:0]    left_mem  [NUM_DEPS];
	logic [SET_W-1:0]    right_mem [NUM_DEPS];
	logic [NUM_DEPS-1:0] live_q;

	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;
	logic [SET_W-1:0]  left_s1;
	logic [SET_W-1:0]  right_s1;
	logic              live_s1;
	logic [SET_W-1:0]  set_q;
	logic [SET_W-1:0]  start_q;
	logic [SET_W-1:0]  target_q;
	logic              changed_q;
	logic              hit;
	logic [SET_W-1:0]  grown;
	logic [SET_W-1:0]  closure_q;
	logic              implied_q;

	assign wr_addr = ADDR_W'(entry_index);
	// writes past the end of the table are dropped
	assign wr_en   = cmd.wr_entry && ({3'b000, entry_index} < 9'(NUM_DEPS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[wr_addr]  <= left_attrs & ATTR_MASK;
			right_mem[wr_addr] <= right_attrs & ATTR_MASK;
		end
		if (cmd.rd_en) begin
			left_s1  <= left_mem[cmd.rd_addr];
			right_s1 <= right_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			live_s1 <= 1'b0;
		end else begin
			if (wr_en) live_q[wr_addr] <= entry_valid;
			if (cmd.rd_en) live_s1 <= live_q[cmd.rd_addr];
		end
	end

	assign hit   = live_s1 && ((left_s1 & ~set_q) == '0);
	assign grown = set_q | right_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (cmd.load_query || cmd.clear_changed) begin
			changed_q <= 1'b0;
		end else if (cmd.apply && hit && (grown != set_q)) begin
			changed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			set_q    <= start_set & ATTR_MASK;
			start_q  <= start_set & ATTR_MASK;
			target_q <= target_set & ATTR_MASK;
		end else if (cmd.apply && hit) begin
			set_q <= grown;
		end
		if (cmd.load_result) begin
			closure_q <= set_q;
			implied_q <= ((target_q & ~start_q) == '0) || ((target_q & ~set_q) == '0);
		end
	end

	assign status.changed = changed_q;
	assign closure_set    = closure_q;
	assign is_implied     = implied_q;

endmodule

`default_nettype wire

// File: rtl/fd_attribute_closure.sv
// functional dependency attribute closure
// item channel: action 0 writes one dependency table entry (left and right
// attribute sets and a live bit), action 1 asks for the closure of start_set
// and whether target_set lies inside it; result channel returns one beat per
// query and none per write
// a write leaves the block idle, so it is ready again in the next cycle
// a query is taken, then the table is scanned one entry per cycle through the
// single read port of the dependency memory, each scan followed by a tail
// state and a check state; scans repeat until one adds nothing, from 1 to
// NUM_ATTRS + 1 passes
// one item is in work at a time; item ready is low while a query runs
// the result sits in an output register: while the receiver stalls, writes
// and a new query are still taken, and only the hand-over of the next
// result waits for the register to be free
// reset clears every live bit, so the table reads as empty; table contents
// need no clearing
`default_nettype none

module fd_attribute_closure import fdac_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fdac_in_if.sink    item,
	fdac_out_if.source result
);

	cmd_t    cmd;
	status_t status;

	fdac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.status    (status),
		.cmd       (cmd)
	);

	fdac_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.entry_index (item.entry_index),
		.entry_valid (item.entry_valid),
		.left_attrs  (item.left_attrs),
		.right_attrs (item.right_attrs),
		.start_set   (item.start_set),
		.target_set  (item.target_set),
		.closure_set (result.closure_set),
		.is_implied  (result.is_implied)
	);

endmodule

`default_nettype wire

// File: rtl/fdac_checker.sv
`default_nettype none

`include "fd_attribute_closure_assert.svh"

module fdac_checker import fdac_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             in_action,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [SET_W-1:0] closure_set,
	input wire logic             is_implied
);

	logic wr_beat;
	logic query_beat;
	logic out_stall;

	assign wr_beat    = in_valid && in_ready && (in_action == ACT_WRITE);
	assign query_beat = in_valid && in_ready && (in_action == ACT_QUERY);
	assign out_stall  = out_valid && !out_ready;

	// a write never produces a result beat
	`FDAC_ASSERT_NEXT(a_write_no_result, clk, arst_n, wr_beat && !out_valid, !out_valid)
	// a query keeps the item channel closed while the scan runs
	`FDAC_ASSERT_NEXT(a_query_busy, clk, arst_n, query_beat, !in_ready && !out_valid || !in_ready)
	`FDAC_ASSERT_NEXT(a_result_held, clk, arst_n, out_stall, out_valid)
	`FDAC_ASSERT_NEXT(a_payload_held, clk, arst_n, out_stall,
		$stable(closure_set) && $stable(is_implied))

endmodule

bind fd_attribute_closure fdac_checker u_fdac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_action   (item.action),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.closure_set (result.closure_set),
	.is_implied  (result.is_implied)
);

`default_nettype wire
